@@ src/esrp_pkg.sv @@
`timescale 1ns / 1ps

package esrp_pkg;

    localparam int MAX_BLOCK_DEF = 32;
    localparam int SIZE_W        = 6;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 8;
    localparam int Q_DEPTH       = 4;

    localparam logic [7:0] ESC_BYTE = 8'h1B;

    localparam logic [CFG_IDX_W-1:0] CFG_DEV_ADDR   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = 1'b1;

    localparam logic [SIZE_W-1:0] BLOCK_SIZE_RST = 6'd32;

    // one framed byte on its way from front to back
    typedef struct packed {
        logic [7:0]        data_byte;
        logic              eoi;
        logic              last;
        logic [SIZE_W-1:0] size;
    } t_tok;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_report;
        logic       end_of_message;
        logic       last_in_run;
    } t_res;

endpackage

@@ src/esrp_in_if.sv @@
`timescale 1ns / 1ps

interface esrp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ src/esrp_out_if.sv @@
`timescale 1ns / 1ps

interface esrp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       end_of_report;
    logic       end_of_message;
    logic       last_in_run;

    modport source (output valid, output out_byte, output end_of_report,
                    output end_of_message, output last_in_run, input ready);
    modport sink   (input valid, input out_byte, input end_of_report,
                    input end_of_message, input last_in_run, output ready);
endinterface

@@ src/esrp_front.sv @@
`timescale 1ns / 1ps

module esrp_front #(
    parameter int MAX_BLOCK = esrp_pkg::MAX_BLOCK_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [7:0]                  i_data_byte,
    input  logic                        i_last_byte,
    input  logic [7:0]                  i_dev_addr,
    input  logic [esrp_pkg::SIZE_W-1:0] i_block_size,
    output logic                        o_tok_valid,
    output esrp_pkg::t_tok              o_tok,
    input  logic                        i_tok_ready
);
    import esrp_pkg::*;

    localparam logic [1:0] ST_HDR  = 2'd0;
    localparam logic [1:0] ST_ADDR = 2'd1;
    localparam logic [1:0] ST_DATA = 2'd2;
    localparam logic [1:0] ST_DUP  = 2'd3;

    localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(MAX_BLOCK);
    localparam logic [SIZE_W-1:0] MIN_SIZE = SIZE_W'(2);

    logic              r_busy;
    logic              r_in_msg;
    logic [1:0]        r_step;
    logic [1:0]        n_step;
    logic [7:0]        r_data;
    logic              r_last;
    logic [7:0]        r_addr;
    logic [SIZE_W-1:0] r_size;
    logic [SIZE_W-1:0] clamped;
    logic [7:0]        tok_byte;
    logic              eoi;
    logic              accept;
    logic              push;

    assign o_ready = !r_busy;
    assign accept  = i_valid && o_ready;
    assign push    = r_busy && i_tok_ready;

    always_comb begin
        if (i_block_size < MIN_SIZE) begin
            clamped = MIN_SIZE;
        end else if (i_block_size > MAX_SIZE) begin
            clamped = MAX_SIZE;
        end else begin
            clamped = i_block_size;
        end
    end

    always_comb begin
        unique case (r_step)
            ST_HDR: begin
                tok_byte = ESC_BYTE;
                n_step   = ST_ADDR;
            end
            ST_ADDR: begin
                tok_byte = r_addr;
                n_step   = ST_DATA;
            end
            ST_DATA: begin
                tok_byte = r_data;
                n_step   = ST_DUP;
            end
            default: begin
                tok_byte = ESC_BYTE;
                n_step   = ST_DUP;
            end
        endcase
    end

    assign eoi = ((r_step == ST_DATA) && (r_data != ESC_BYTE)) || (r_step == ST_DUP);

    assign o_tok_valid    = r_busy;
    assign o_tok.data_byte = tok_byte;
    assign o_tok.eoi       = eoi;
    assign o_tok.last      = r_last;
    assign o_tok.size      = r_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_in_msg <= 1'b0;
            r_step   <= ST_HDR;
        end else if (accept) begin
            r_busy   <= 1'b1;
            r_in_msg <= !i_last_byte;
            r_step   <= r_in_msg ? ST_DATA : ST_HDR;
        end else if (push) begin
            r_step <= n_step;
            if (eoi) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data <= i_data_byte;
            r_last <= i_last_byte;
            r_addr <= i_dev_addr;
            if (!r_in_msg) begin
                r_size <= clamped;
            end
        end
    end

endmodule

@@ src/esrp_fifo.sv @@
`timescale 1ns / 1ps

module esrp_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  esrp_pkg::t_tok i_tok,
    output logic           o_valid,
    input  logic           i_pop,
    output esrp_pkg::t_tok o_tok
);
    import esrp_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_tok             r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             wr_en;
    logic             rd_en;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_ready = (r_cnt != CNT_W'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_tok   = r_mem[r_rd];
    assign wr_en   = i_valid && o_ready;
    assign rd_en   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (rd_en) begin
                r_rd <= ptr_inc(r_rd);
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_tok;
        end
    end

endmodule

@@ src/esrp_back.sv @@
`timescale 1ns / 1ps

module esrp_back #(
    parameter int MAX_BLOCK = esrp_pkg::MAX_BLOCK_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  esrp_pkg::t_tok i_q_tok,
    output logic           o_q_pop,
    output logic           o_res_valid,
    output esrp_pkg::t_res o_res,
    input  logic           i_res_ready
);
    import esrp_pkg::*;

    localparam int PTR_W = $clog2(MAX_BLOCK);
    localparam int CNT_W = $clog2(MAX_BLOCK + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PUSH  = 3'd1;
    localparam logic [2:0] S_FLUSH = 3'd2;
    localparam logic [2:0] S_RPT   = 3'd3;
    localparam logic [2:0] S_EOI   = 3'd4;

    logic [7:0]        r_mem [MAX_BLOCK];
    logic [2:0]        r_state, n_state;
    t_tok              r_tok, n_tok;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [PTR_W-1:0]  r_rd, n_rd;
    logic [PTR_W-1:0]  r_wr, n_wr;
    logic [SIZE_W-1:0] r_pos, n_pos;
    logic [SIZE_W-1:0] r_used, n_used;
    logic              r_raw, n_raw;
    logic              r_eom, n_eom;
    logic              r_flush, n_flush;
    t_res              r_hold, n_hold;
    logic              r_hold_v, n_hold_v;
    t_res              r_out, n_out;
    logic              r_ov, n_ov;

    logic [SIZE_W-1:0] cnt_ext;
    logic [SIZE_W-1:0] bs;
    logic [7:0]        head;
    logic              out_free;
    logic              emit_ok;
    logic              full_blk;
    logic              rpt_raw;
    logic [SIZE_W-1:0] rpt_used;
    logic              consume;
    logic              eor;
    logic [7:0]        emit_byte;
    logic              do_push;
    t_tok              p_tok;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(MAX_BLOCK - 1)) ? '0 : p + 1'b1;
    endfunction

    assign cnt_ext  = SIZE_W'(r_cnt);
    assign bs       = r_tok.size;
    assign head     = r_mem[r_rd];
    assign out_free = !r_ov || i_res_ready;
    assign emit_ok  = !r_hold_v || out_free;

    assign full_blk = (cnt_ext >= bs);
    assign rpt_raw  = full_blk && (head >= 8'(bs));
    assign rpt_used = rpt_raw ? bs : (full_blk ? bs - 1'b1 : cnt_ext);

    assign consume   = r_raw || ((r_pos != '0) && (r_pos <= r_used));
    assign emit_byte = consume ? head : ((r_pos == '0) ? 8'(r_used) : 8'h00);
    assign eor       = (r_pos == bs - 1'b1);

    always_comb begin
        n_state  = r_state;
        n_tok    = r_tok;
        n_cnt    = r_cnt;
        n_rd     = r_rd;
        n_wr     = r_wr;
        n_pos    = r_pos;
        n_used   = r_used;
        n_raw    = r_raw;
        n_eom    = r_eom;
        n_flush  = r_flush;
        n_hold   = r_hold;
        n_hold_v = r_hold_v;
        n_out    = r_out;
        n_ov     = r_ov && !i_res_ready;
        o_q_pop  = 1'b0;
        do_push  = 1'b0;
        p_tok    = r_tok;

        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_tok   = i_q_tok;
                    if (cnt_ext < i_q_tok.size) begin
                        do_push = 1'b1;
                        p_tok   = i_q_tok;
                    end else begin
                        n_state = S_PUSH;
                    end
                end
            end
            S_PUSH: begin
                if (full_blk) begin
                    n_raw   = rpt_raw;
                    n_used  = rpt_used;
                    n_eom   = 1'b0;
                    n_flush = 1'b0;
                    n_pos   = '0;
                    n_state = S_RPT;
                end else begin
                    do_push = 1'b1;
                end
            end
            S_FLUSH: begin
                if (r_cnt != '0) begin
                    n_raw   = rpt_raw;
                    n_used  = rpt_used;
                    n_eom   = (cnt_ext == rpt_used);
                    n_flush = 1'b1;
                    n_pos   = '0;
                    n_state = S_RPT;
                end else begin
                    n_state = S_EOI;
                end
            end
            S_RPT: begin
                if (emit_ok) begin
                    if (r_hold_v) begin
                        n_out             = r_hold;
                        n_out.last_in_run = 1'b0;
                        n_ov              = 1'b1;
                    end
                    n_hold.out_byte       = emit_byte;
                    n_hold.end_of_report  = eor;
                    n_hold.end_of_message = r_eom && eor;
                    n_hold.last_in_run    = 1'b0;
                    n_hold_v              = 1'b1;
                    n_pos                 = r_pos + 1'b1;
                    if (consume) begin
                        n_rd  = ptr_inc(r_rd);
                        n_cnt = n_cnt - 1'b1;
                    end
                    if (eor) begin
                        n_state = r_flush ? S_FLUSH : S_PUSH;
                    end
                end
            end
            S_EOI: begin
                if (!r_hold_v) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out             = r_hold;
                    n_out.last_in_run = 1'b1;
                    n_ov              = 1'b1;
                    n_hold_v          = 1'b0;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // byte enters the pending store; then close the input beat if it was its last
        if (do_push) begin
            n_cnt = r_cnt + 1'b1;
            n_wr  = ptr_inc(r_wr);
            if (!p_tok.eoi) begin
                n_state = S_IDLE;
            end else if (p_tok.last) begin
                n_state = S_FLUSH;
            end else if (!r_hold_v) begin
                n_state = S_IDLE;
            end else if (out_free) begin
                n_out             = r_hold;
                n_out.last_in_run = 1'b1;
                n_ov              = 1'b1;
                n_hold_v          = 1'b0;
                n_state           = S_IDLE;
            end else begin
                n_state = S_EOI;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_rd     <= '0;
            r_wr     <= '0;
            r_hold_v <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_rd     <= n_rd;
            r_wr     <= n_wr;
            r_hold_v <= n_hold_v;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok   <= n_tok;
        r_pos   <= n_pos;
        r_used  <= n_used;
        r_raw   <= n_raw;
        r_eom   <= n_eom;
        r_flush <= n_flush;
        r_hold  <= n_hold;
        r_out   <= n_out;
        if (do_push) begin
            r_mem[r_wr] <= p_tok.data_byte;
        end
    end

    assign o_res_valid = r_ov;
    assign o_res       = r_out;

endmodule

@@ src/escape_stuff_report_packer_top.sv @@
`timescale 1ns / 1ps

// channel   dir  handshake     payload
// i_in      in   valid/ready   data_byte[7:0], last_byte
// o_out     out  valid/ready   out_byte[7:0], end_of_report, end_of_message, last_in_run
// i_cfg_*   in   write enable  i_cfg_idx selects register, i_cfg_data[7:0]
//
// Front: accepts an item, then sends its framed bytes (1 to 4), one per cycle unless the
// queue is full, and takes no new item until done. Back: stores one byte per cycle when
// idle; S_RPT emits block size bytes a report; at a message end S_EOI tags the last beat.
// Reset clears control state only; the pending byte store needs no clearing.
// Either side may stall freely; the output register holds a beat until taken.

module escape_stuff_report_packer_top #(
    parameter int MAX_BLOCK = esrp_pkg::MAX_BLOCK_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    esrp_in_if.sink                         i_in,
    esrp_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic [esrp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [esrp_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import esrp_pkg::*;

    logic [7:0]        r_dev_addr;
    logic [SIZE_W-1:0] r_block_size;

    logic front_ready;
    logic tok_valid;
    t_tok tok;
    logic tok_ready;
    logic q_valid;
    t_tok q_tok;
    logic q_pop;
    logic res_valid;
    t_res res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr   <= '0;
            r_block_size <= BLOCK_SIZE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DEV_ADDR:   r_dev_addr   <= i_cfg_data;
                CFG_BLOCK_SIZE: r_block_size <= i_cfg_data[SIZE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    esrp_front #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in.valid),
        .o_ready      (front_ready),
        .i_data_byte  (i_in.data_byte),
        .i_last_byte  (i_in.last_byte),
        .i_dev_addr   (r_dev_addr),
        .i_block_size (r_block_size),
        .o_tok_valid  (tok_valid),
        .o_tok        (tok),
        .i_tok_ready  (tok_ready)
    );

    assign i_in.ready = front_ready;

    esrp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (tok_valid),
        .o_ready (tok_ready),
        .i_tok   (tok),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_tok   (q_tok)
    );

    esrp_back #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_tok     (q_tok),
        .o_q_pop     (q_pop),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (o_out.ready)
    );

    assign o_out.valid          = res_valid;
    assign o_out.out_byte       = res.out_byte;
    assign o_out.end_of_report  = res.end_of_report;
    assign o_out.end_of_message = res.end_of_message;
    assign o_out.last_in_run    = res.last_in_run;

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import esrp_pkg::*;

    localparam int          MAXB          = MAX_BLOCK_DEF;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int          SETTLE_CYCLES = 24;
    localparam int          HOLD_CYCLES   = 300;

    class report_board;
        logic [7:0]  pend [0:MAXB];
        int unsigned pend_cnt;
        bit          in_msg;
        int unsigned act_size;
        logic [7:0]  dev_addr;
        logic [5:0]  blk_size;
        t_res        report_q[$];
        int unsigned errors, n_beats, n_msgs, n_raw, n_len, n_checked;

        function new();
            pend_cnt = 0;
            in_msg   = 1'b0;
            act_size = MAXB;
            dev_addr = 8'h00;
            blk_size = BLOCK_SIZE_RST;
            errors   = 0;
            n_beats  = 0;
            n_msgs   = 0;
            n_raw    = 0;
            n_len    = 0;
            n_checked = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
            if (idx == CFG_DEV_ADDR)
                dev_addr = val;
            else if (idx == CFG_BLOCK_SIZE)
                blk_size = val[5:0];
        endfunction

        function void put(logic [7:0] b, bit eor, bit eom);
            t_res r;
            r.out_byte       = b;
            r.end_of_report  = eor;
            r.end_of_message = eom;
            r.last_in_run    = 1'b0;
            report_q.push_back(r);
        endfunction

        function void ship_report(bit flushing);
            int unsigned used, k;
            bit eom;
            if (pend_cnt >= act_size && pend[0] >= act_size) begin
                used = act_size;
                eom  = flushing && (pend_cnt == used);
                for (k = 0; k < act_size; k++)
                    put(pend[k], k + 1 == act_size, eom && (k + 1 == act_size));
                n_raw++;
            end else begin
                used = (pend_cnt >= act_size) ? act_size - 1 : pend_cnt;
                eom  = flushing && (pend_cnt == used);
                put(used[7:0], 1'b0, 1'b0);
                for (k = 1; k < act_size; k++)
                    put((k <= used) ? pend[k - 1] : 8'h00, k + 1 == act_size,
                        eom && (k + 1 == act_size));
                n_len++;
            end
            for (k = 0; k + used < pend_cnt; k++)
                pend[k] = pend[k + used];
            pend_cnt = pend_cnt - used;
        endfunction

        function void stage(logic [7:0] b);
            if (pend_cnt >= act_size)
                ship_report(1'b0);
            pend[pend_cnt] = b;
            pend_cnt++;
        endfunction

        function void note_cmd_byte(logic [7:0] d, bit last);
            int unsigned base;
            t_res tail;
            base = report_q.size();
            if (!in_msg) begin
                act_size = (blk_size < 2) ? 2 : (blk_size > MAXB) ? MAXB : blk_size;
                in_msg   = 1'b1;
                stage(ESC_BYTE);
                stage(dev_addr);
                n_msgs++;
            end
            stage(d);
            if (d == ESC_BYTE)
                stage(ESC_BYTE);
            if (last) begin
                while (pend_cnt > 0)
                    ship_report(1'b1);
                in_msg = 1'b0;
            end
            if (report_q.size() > base) begin
                tail = report_q.pop_back();
                tail.last_in_run = 1'b1;
                report_q.push_back(tail);
            end
            n_beats++;
        endfunction

        function void check_out(t_res got);
            t_res want;
            bit bad;
            bad = 1'b0;
            if (report_q.size() == 0) begin
                $error("report beat %02h with nothing expected", got.out_byte);
                errors++;
                return;
            end
            want = report_q.pop_front();
            n_checked++;
            if (got.out_byte !== want.out_byte) begin
                $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
                bad = 1'b1;
            end
            if (got.end_of_report !== want.end_of_report) begin
                $error("end_of_report: expected %0b, got %0b",
                       want.end_of_report, got.end_of_report);
                bad = 1'b1;
            end
            if (got.end_of_message !== want.end_of_message) begin
                $error("end_of_message: expected %0b, got %0b",
                       want.end_of_message, got.end_of_message);
                bad = 1'b1;
            end
            if (got.last_in_run !== want.last_in_run) begin
                $error("last_in_run: expected %0b, got %0b",
                       want.last_in_run, got.last_in_run);
                bad = 1'b1;
            end
            if (bad)
                errors++;
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    esrp_in_if  in_if();
    esrp_out_if out_if();

    report_board board;
    int          src_idle_pct = 0;
    int          rx_stall_pct = 0;
    int          hold_reqs    = 0;
    int unsigned cycle_cnt    = 0;

    escape_stuff_report_packer_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // result side: random stalls plus an occasional long hold-off
    initial begin
        int   hold_left;
        int   holds_done;
        t_res got;
        hold_left  = 0;
        holds_done = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready) begin
                got.out_byte       = out_if.out_byte;
                got.end_of_report  = out_if.end_of_report;
                got.end_of_message = out_if.end_of_message;
                got.last_in_run    = out_if.last_in_run;
                board.check_out(got);
            end
            if (hold_reqs != holds_done) begin
                holds_done++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    task automatic send_beat(input logic [7:0] d, input logic last);
        while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.data_byte <= d;
        in_if.last_byte <= last;
        do @(posedge i_clk); while (!in_if.ready);
        board.note_cmd_byte(d, last);
    endtask

    task automatic settle();
        in_if.valid <= 1'b0;
        while (board.report_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic reconfig(input logic [7:0] addr, input logic [5:0] bsz);
        logic [7:0] wd;
        wd      = 8'($urandom_range(255));
        wd[5:0] = bsz;
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_DEV_ADDR;
        i_cfg_data <= addr;
        @(posedge i_clk);
        board.write_reg(CFG_DEV_ADDR, addr);
        i_cfg_idx  <= CFG_BLOCK_SIZE;
        i_cfg_data <= wd;
        @(posedge i_clk);
        board.write_reg(CFG_BLOCK_SIZE, wd);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic pick_cfg();
        logic [7:0] a;
        logic [5:0] s;
        case ($urandom_range(9))
            0:       s = 6'd0;
            1:       s = 6'd1;
            2:       s = 6'd2;
            3:       s = 6'd32;
            4:       s = 6'd63;
            5:       s = 6'd33;
            6:       s = 6'($urandom_range(63));
            default: s = 6'($urandom_range(3, 16));
        endcase
        a = ($urandom_range(7) == 0) ? ESC_BYTE : 8'($urandom_range(255));
        reconfig(a, s);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(9))
            0, 1:    return ESC_BYTE;
            2:       return 8'($urandom_range(32, 255));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // sends one command; may retune registers mid command while the block is idle
    task automatic send_msg(output int len);
        int k;
        len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
        for (k = 0; k < len; k++) begin
            send_beat(pick_byte(), k + 1 == len);
            if (k + 1 < len && $urandom_range(19) == 0)
                pick_cfg();
        end
    endtask

    initial begin
        int ph, sent, len;
        board = new();
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= CFG_DEV_ADDR;
        i_cfg_data      <= '0;
        in_if.valid     <= 1'b0;
        in_if.data_byte <= '0;
        in_if.last_byte <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset config, escapes, size clamping, mid-message changes
        send_beat(8'h00, 1'b1);
        send_beat(8'hFF, 1'b0);
        send_beat(ESC_BYTE, 1'b0);
        send_beat(ESC_BYTE, 1'b1);
        reconfig(8'hFF, 6'd0);
        send_beat(ESC_BYTE, 1'b0);
        send_beat(8'h80, 1'b1);
        reconfig(ESC_BYTE, 6'd1);
        send_beat(8'h01, 1'b1);
        reconfig(8'h00, 6'd2);
        send_beat(ESC_BYTE, 1'b1);
        reconfig(8'h5A, 6'd63);
        send_beat(8'hFF, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h00, 1'b1);
        reconfig(8'hA5, 6'd33);
        send_beat(8'h7F, 1'b1);
        reconfig(8'h3C, 6'd4);
        send_beat(8'hC3, 1'b0);
        send_beat(ESC_BYTE, 1'b0);
        reconfig(8'h11, 6'd8);
        send_beat(8'h22, 1'b0);
        send_beat(8'h05, 1'b1);
        send_beat(8'h40, 1'b1);
        reconfig(8'h00, 6'd32);
        send_beat(8'h55, 1'b0);
        send_beat(8'hAA, 1'b1);

        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       begin src_idle_pct = 0;  rx_stall_pct = 0;  end
                1:       begin src_idle_pct = 65; rx_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  rx_stall_pct = 65; end
                default: begin src_idle_pct = 18; rx_stall_pct = 18; end
            endcase
            pick_cfg();
            sent = 0;
            while (sent < 45) begin
                send_msg(len);
                sent += len;
                if ($urandom_range(3) == 0)
                    pick_cfg();
            end
            settle();
        end

        // backpressure: output held off while input keeps coming
        src_idle_pct = 0;
        rx_stall_pct = 0;
        reconfig(8'($urandom_range(255)), 6'($urandom_range(2, 8)));
        hold_reqs++;
        sent = 0;
        while (sent < 30) begin
            send_msg(len);
            sent += len;
        end
        settle();

        repeat (40) @(posedge i_clk);
        $display("%0d command beats in %0d commands; %0d report beats checked",
                 board.n_beats, board.n_msgs, board.n_checked);
        $display("reports: %0d raw, %0d length-prefixed", board.n_raw, board.n_len);
        if (board.errors == 0 && board.report_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
src/esrp_pkg.sv
src/esrp_in_if.sv
src/esrp_out_if.sv
src/esrp_front.sv
src/esrp_fifo.sv
src/esrp_back.sv
src/escape_stuff_report_packer_top.sv
test/tb.sv
